FILE: hw/rtl/sstr_pkg.sv
// ----------------------------------------------------------------------------
// sstr_pkg
// Shared types and constants for the system-information string finder.
// ----------------------------------------------------------------------------
package sstr_pkg;

    // Structure type that closes the table, and the smallest legal length.
    localparam logic [7:0] TYPE_END   = 8'd127;
    localparam logic [7:0] MIN_LENGTH = 8'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WANTED_TYPE     = 2'd0;
    localparam logic [1:0] CFG_WANTED_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_STRUCTURE_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  RST_WANTED_TYPE     = 8'd2;
    localparam logic [7:0]  RST_WANTED_OFFSET   = 8'd4;
    localparam logic [15:0] RST_STRUCTURE_LIMIT = 16'd0;

    // Input word kinds.
    localparam logic KIND_RESTART = 1'b0;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_STRINGS = 2'd1,
        PH_EMIT    = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_FOUND     = 2'd1,
        ST_MISSING   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  wanted_type;
        logic [7:0]  wanted_offset;
        logic [15:0] structure_limit;
    } t_cfg;

    typedef struct packed {
        logic    prev_zero;
        logic    at_start;
        logic    lookup;
    } t_flags;

    typedef struct packed {
        t_status    status;
        logic       answer_valid;
        logic [7:0] answer_byte;
    } t_result;

endpackage

FILE: hw/rtl/sstr_core.sv
// ----------------------------------------------------------------------------
// sstr_core
// Search state and the per-word update: walks the structure headers, counts
// strings and picks out the characters of the wanted string.
// ----------------------------------------------------------------------------
module sstr_core
    import sstr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic       i_kind,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_pos,       n_pos;
    logic [7:0]  r_length,    n_length;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_wanted_no, n_wanted_no;
    logic [7:0]  r_counter,   n_counter;
    t_flags      r_flags,     n_flags;
    logic [15:0] r_seen,      n_seen;
    t_status     r_status,    n_status;

    // State register: updated once for every word that moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_length    <= '0;
            r_type      <= '0;
            r_wanted_no <= '0;
            r_counter   <= 8'd1;
            r_flags     <= '0;
            r_seen      <= '0;
            r_status    <= ST_SEARCHING;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_length    <= n_length;
            r_type      <= n_type;
            r_wanted_no <= n_wanted_no;
            r_counter   <= n_counter;
            r_flags     <= n_flags;
            r_seen      <= n_seen;
            r_status    <= n_status;
        end
    end

    // Next state and the result for the current word.
    always_comb begin
        logic [7:0]  len_v;
        logic [7:0]  type_v;
        logic [7:0]  no_v;
        logic [7:0]  pos_inc;
        logic [15:0] seen_v;
        logic        match;
        logic        emit;
        t_flags      fl;
        logic [7:0]  cnt;

        n_phase     = r_phase;
        n_pos       = r_pos;
        n_length    = r_length;
        n_type      = r_type;
        n_wanted_no = r_wanted_no;
        n_counter   = r_counter;
        n_flags     = r_flags;
        n_seen      = r_seen;
        n_status    = r_status;
        emit        = 1'b0;
        len_v       = r_length;
        type_v      = r_type;
        no_v        = r_wanted_no;
        pos_inc     = r_pos + 8'd1;
        seen_v      = r_seen;
        match       = 1'b0;
        fl          = r_flags;
        cnt         = r_counter;

        if (i_kind == KIND_RESTART) begin
            n_phase     = PH_HEADER;
            n_pos       = '0;
            n_length    = '0;
            n_type      = '0;
            n_wanted_no = '0;
            n_counter   = 8'd1;
            n_flags     = '0;
            n_seen      = '0;
            n_status    = ST_SEARCHING;
            if (i_cfg.structure_limit == 16'd0) begin
                n_status = ST_MISSING;
                n_phase  = PH_DONE;
            end
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == 8'd0 &&
                        (r_seen >= i_cfg.structure_limit || i_byte == TYPE_END)) begin
                        n_status = ST_MISSING;
                        n_phase  = PH_DONE;
                    end else if (r_pos == 8'd1 && i_byte < MIN_LENGTH) begin
                        n_status = ST_MISSING;
                        n_phase  = PH_DONE;
                    end else begin
                        // Capture the header fields and the string number.
                        if (r_pos == 8'd0) begin
                            type_v = i_byte;
                            no_v   = '0;
                        end
                        if (r_pos == 8'd1) begin
                            len_v = i_byte;
                        end
                        if (r_pos == i_cfg.wanted_offset) begin
                            no_v = i_byte;
                        end
                        n_type      = type_v;
                        n_length    = len_v;
                        n_wanted_no = no_v;
                        // The formatted area ends: decide the match now.
                        if (r_pos != 8'd0 && pos_inc >= len_v) begin
                            match = (type_v == i_cfg.wanted_type) &&
                                    (len_v > i_cfg.wanted_offset) &&
                                    (no_v != 8'd0);
                            n_phase   = PH_STRINGS;
                            n_counter = 8'd1;
                            n_flags   = '{prev_zero: 1'b0, at_start: 1'b1, lookup: match};
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                end
                PH_STRINGS: begin
                    // String counting while the lookup is still live.
                    if (fl.lookup) begin
                        if (fl.at_start) begin
                            if (i_byte == 8'd0) begin
                                fl.lookup = 1'b0;
                            end else if (cnt == r_wanted_no) begin
                                emit = 1'b1;
                            end else begin
                                fl.at_start = 1'b0;
                            end
                        end else if (i_byte == 8'd0) begin
                            fl.at_start = 1'b1;
                            cnt         = cnt + 8'd1;
                        end
                    end
                    n_counter = cnt;
                    if (emit) begin
                        n_phase = PH_EMIT;
                    end else if (i_byte == 8'd0 && fl.prev_zero) begin
                        // Two zeros in a row close the structure.
                        if (r_seen != 16'hFFFF) begin
                            seen_v = r_seen + 16'd1;
                        end
                        n_seen = seen_v;
                        if (seen_v >= i_cfg.structure_limit) begin
                            n_status = ST_MISSING;
                            n_phase  = PH_DONE;
                        end else begin
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                        end
                    end else begin
                        fl.prev_zero = (i_byte == 8'd0);
                    end
                    n_flags = fl;
                end
                PH_EMIT: begin
                    if (i_byte == 8'd0) begin
                        n_status = ST_FOUND;
                        n_phase  = PH_DONE;
                    end else begin
                        emit = 1'b1;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        o_result.answer_valid = emit;
        o_result.answer_byte  = emit ? i_byte : 8'd0;
        o_result.status       = n_status;
    end

    // A character is only ever produced while a string set is being read.
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_result.answer_valid |->
            (r_phase == PH_STRINGS || r_phase == PH_EMIT))
        else $error("character produced outside a string set");

    // A final status always comes with the finished phase.
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status != ST_SEARCHING |-> r_phase == PH_DONE)
        else $error("final status without finished phase");

    // The wanted string is only entered through a live lookup.
    a_emit_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EMIT |-> r_flags.lookup && r_wanted_no != 8'd0)
        else $error("string emission without lookup");

    // A restart with a nonzero limit puts the search back to searching.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_kind == KIND_RESTART && i_cfg.structure_limit != 16'd0 |=>
            r_status == ST_SEARCHING && r_phase == PH_HEADER && r_seen == 16'd0)
        else $error("restart did not clear the search");

endmodule

FILE: hw/rtl/smbios_structure_string_finder.sv
// ----------------------------------------------------------------------------
// smbios_structure_string_finder
// Scans a structure table word by word and streams out the characters of
// the wanted string field of the first matching structure.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: kind; tdata: table byte
//  m_axis    out        tuser: answer valid; tdata: answer byte, status
//  cfg       in         write enable, register index, 16-bit write data
//
// One word is taken every cycle unless m_axis stalls. It waits in the input
// register; the single state update per byte then sets the output register.
// Reset (synchronous, active low) clears the search and loads register
// defaults. A stall on m_axis holds the result; the input register then
// fills and s_axis_tready falls until the output is taken.
// ----------------------------------------------------------------------------
module smbios_structure_string_finder
    import sstr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] table byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] answer byte, [9:8] status, zero fill
    output logic        m_axis_tuser,   // [0] answer valid
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       advance;

    // The input word moves on whenever the output register is free or drains.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wanted_type     <= RST_WANTED_TYPE;
            r_cfg.wanted_offset   <= RST_WANTED_OFFSET;
            r_cfg.structure_limit <= RST_STRUCTURE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WANTED_TYPE:     r_cfg.wanted_type     <= i_cfg_data[7:0];
                CFG_WANTED_OFFSET:   r_cfg.wanted_offset   <= i_cfg_data[7:0];
                CFG_STRUCTURE_LIMIT: r_cfg.structure_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    sstr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_kind    (r_in_kind),
        .i_byte    (r_in_byte),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.answer_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.answer_byte};

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the structure string finder. A short scripted
// table covers the end-of-search cases and one complete string hit. After
// it come random structure tables, mostly well formed and some broken, under
// several register settings and three patterns of idling on each stream.
// Every result word is checked against a cycle-free model of the search.
// ----------------------------------------------------------------------------
module tb
    import sstr_pkg::*;
;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TABLE_WORDS = 2000;
    localparam int SETTINGS_N  = 9;
    localparam int MAX_PRINTS  = 20;
    localparam logic KIND_BYTE = ~KIND_RESTART;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } t_word;

    typedef struct {
        logic        is_write;
        logic [1:0]  index;
        logic [15:0] value;
        logic        kind;
        logic [7:0]  data;
        logic        known;
        t_status     status;
    } t_row;

    // Block ports; every input is known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = KIND_RESTART;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_WANTED_TYPE;
    logic [15:0] i_cfg_data = '0;

    // Model copy of the registers and of the search state.
    logic [7:0]  cfg_type;
    logic [7:0]  cfg_offset;
    logic [15:0] cfg_limit;
    t_phase      scan_phase;
    logic [7:0]  scan_pos;
    logic [7:0]  scan_len;
    logic [7:0]  scan_type;
    logic [7:0]  scan_str_no;
    logic [7:0]  scan_str_count;
    t_flags      scan_flags;
    logic [15:0] scan_seen;
    t_status     scan_status;

    // Answers still owed by the block, oldest first, and the stimulus stores.
    t_result     pending_answers[$];
    t_result     oldest_answer;
    t_word       table_words[$];
    t_row        directed_rows[$];
    logic [7:0]  sample_table [17] = '{8'h02, 8'h05, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00,
                                       8'h02, 8'h05, 8'h00, 8'h00, 8'h02,
                                       8'h61, 8'h00, 8'h62, 8'h63, 8'h00};

    int          send_idle_pct = 28;
    int          recv_idle_pct = 50;
    int unsigned cycle_count = 0;
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          live_words = 0;
    int          answers_checked = 0;
    int          found_searches = 0;
    int          missing_searches = 0;
    int          chars_streamed = 0;

    smbios_structure_string_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] table byte
        .s_axis_tuser  (s_axis_tuser),   // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] answer byte, [9:8] status, zero fill
        .m_axis_tuser  (m_axis_tuser),   // [0] answer valid
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Search model
    // ------------------------------------------------------------------------

    function automatic void restart_scan();
        scan_phase     = PH_HEADER;
        scan_pos       = '0;
        scan_len       = '0;
        scan_type      = '0;
        scan_str_no    = '0;
        scan_str_count = 8'd1;
        scan_flags     = '0;
        scan_seen      = '0;
        scan_status    = ST_SEARCHING;
    endfunction

    function automatic void end_scan(input t_status st);
        scan_status = st;
        scan_phase  = PH_DONE;
    endfunction

    // A structure's string set has closed; stop once the table is used up.
    function automatic void close_structure();
        if (scan_seen != 16'hFFFF) scan_seen = scan_seen + 16'd1;
        if (scan_seen >= cfg_limit) begin
            end_scan(ST_MISSING);
        end else begin
            scan_phase = PH_HEADER;
            scan_pos   = '0;
        end
    endfunction

    // Header and formatted area: capture type, length and the string number.
    function automatic void take_header_byte(input logic [7:0] b);
        logic [7:0] pos;
        logic [7:0] next_pos;
        pos      = scan_pos;
        next_pos = pos + 8'd1;
        if (pos == 8'd0) begin
            if (scan_seen >= cfg_limit || b == TYPE_END) begin
                end_scan(ST_MISSING);
                return;
            end
            scan_type   = b;
            scan_str_no = '0;
        end else if (pos == 8'd1) begin
            if (b < MIN_LENGTH) begin
                end_scan(ST_MISSING);
                return;
            end
            scan_len = b;
        end
        if (pos == cfg_offset) scan_str_no = b;
        if (pos >= 8'd1 && next_pos >= scan_len) begin
            // The match is settled here, as the string set begins.
            scan_phase           = PH_STRINGS;
            scan_str_count       = 8'd1;
            scan_flags           = '0;
            scan_flags.at_start  = 1'b1;
            scan_flags.lookup    = scan_type == cfg_type && scan_len > cfg_offset &&
                                   scan_str_no != 8'd0;
            return;
        end
        scan_pos = next_pos;
    endfunction

    // String set: count strings and spot the first character of the wanted one.
    function automatic logic take_string_byte(input logic [7:0] b);
        if (scan_flags.lookup) begin
            if (scan_flags.at_start) begin
                if (b == 8'd0) begin
                    scan_flags.lookup = 1'b0;
                end else if (scan_str_count == scan_str_no) begin
                    scan_phase = PH_EMIT;
                    return 1'b1;
                end else begin
                    scan_flags.at_start = 1'b0;
                end
            end else if (b == 8'd0) begin
                scan_flags.at_start = 1'b1;
                scan_str_count      = scan_str_count + 8'd1;
            end
        end
        if (b == 8'd0 && scan_flags.prev_zero) begin
            close_structure();
            return 1'b0;
        end
        scan_flags.prev_zero = (b == 8'd0);
        return 1'b0;
    endfunction

    function automatic t_result predict_answer(input logic kind, input logic [7:0] b);
        t_result r;
        logic    hit;
        hit = 1'b0;
        if (kind == KIND_RESTART) begin
            restart_scan();
            if (cfg_limit == 16'd0) end_scan(ST_MISSING);
        end else begin
            case (scan_phase)
                PH_HEADER: begin
                    take_header_byte(b);
                end
                PH_STRINGS: begin
                    hit = take_string_byte(b);
                end
                PH_EMIT: begin
                    if (b == 8'd0) end_scan(ST_FOUND);
                    else hit = 1'b1;
                end
                default: begin
                end
            endcase
        end
        r.answer_byte  = hit ? b : 8'd0;
        r.answer_valid = hit;
        r.status       = scan_status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    function automatic void add_word(input logic kind, input logic [7:0] b);
        t_word w;
        w.kind  = kind;
        w.value = b;
        table_words.push_back(w);
    endfunction

    function automatic void row_word(input logic kind, input logic [7:0] b);
        t_row r;
        r          = '{status: ST_SEARCHING, default: '0};
        r.kind     = kind;
        r.data     = b;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_known(input logic kind, input logic [7:0] b,
                                      input t_status st);
        t_row r;
        r          = '{status: ST_SEARCHING, default: '0};
        r.kind     = kind;
        r.data     = b;
        r.known    = 1'b1;
        r.status   = st;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_write(input logic [1:0] index, input logic [15:0] value);
        t_row r;
        r          = '{status: ST_SEARCHING, default: '0};
        r.is_write = 1'b1;
        r.index    = index;
        r.value    = value;
        directed_rows.push_back(r);
    endfunction

    // One structure with random content, now and then malformed or cut short.
    function automatic void add_structure();
        int         roll;
        int         length;
        int         floor_len;
        int         n_strings;
        int         start;
        logic [7:0] type_byte;
        start = table_words.size();
        roll  = $urandom_range(99);
        if (roll < 45) type_byte = cfg_type;
        else if (roll < 50) type_byte = TYPE_END;
        else type_byte = 8'($urandom_range(255));
        floor_len = (cfg_offset < 8'd16 && cfg_offset >= 8'd4) ? int'(cfg_offset) + 1 : 4;
        roll      = $urandom_range(99);
        if (roll < 4) length = $urandom_range(3);
        else if (roll < 6) length = 255;
        else if (roll < 70) length = $urandom_range(floor_len, floor_len + 3);
        else length = $urandom_range(4, 20);
        n_strings = $urandom_range(5);
        add_word(KIND_BYTE, type_byte);
        add_word(KIND_BYTE, 8'(length));
        for (int pos = 2; pos < length; pos++) begin
            if (pos == int'(cfg_offset)) add_word(KIND_BYTE, 8'($urandom_range(n_strings + 1)));
            else add_word(KIND_BYTE, 8'($urandom_range(255)));
        end
        for (int s = 0; s < n_strings; s++) begin
            repeat ($urandom_range(1, 6)) add_word(KIND_BYTE, 8'($urandom_range(1, 255)));
            add_word(KIND_BYTE, 8'd0);
        end
        add_word(KIND_BYTE, 8'd0);
        if (n_strings == 0) add_word(KIND_BYTE, 8'd0);
        // A broken structure stops part way; the next restart picks up.
        if ($urandom_range(99) < 5) begin
            roll = $urandom_range(table_words.size() - start - 1);
            while (table_words.size() > start + roll) void'(table_words.pop_back());
        end
    endfunction

    // A table walk: usually a restart, then a few structures; sometimes noise first.
    function automatic void add_sequence();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            repeat ($urandom_range(1, 12)) begin
                add_word(($urandom_range(7) == 0) ? KIND_RESTART : KIND_BYTE,
                         8'($urandom_range(255)));
            end
        end
        if (roll >= 4) add_word(KIND_RESTART, 8'($urandom_range(255)));
        repeat ($urandom_range(1, 6)) add_structure();
    endfunction

    // ------------------------------------------------------------------------
    // Stream and register drivers
    // ------------------------------------------------------------------------

    // Offer one word, possibly after idle cycles, and record its answer.
    task automatic send_word(input logic kind, input logic [7:0] b, input logic known,
                             input t_result typed);
        t_result predicted;
        t_status was;
        logic    live;
        live      = (kind == KIND_RESTART) || (scan_phase != PH_DONE);
        was       = scan_status;
        predicted = predict_answer(kind, b);
        if (predicted.answer_valid) chars_streamed++;
        if (was != ST_FOUND && scan_status == ST_FOUND) found_searches++;
        if (kind == KIND_RESTART || was != ST_MISSING) begin
            if (scan_status == ST_MISSING) missing_searches++;
        end
        if (known) predicted = typed;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle_pct) s_axis_tvalid <= 1'b0;
            else break;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(predicted);
        words_sent++;
        if (live) live_words++;
    endtask

    // Hold the input stream until every owed answer is back.
    task automatic wait_until_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_WANTED_TYPE:     cfg_type   = value[7:0];
            CFG_WANTED_OFFSET:   cfg_offset = value[7:0];
            CFG_STRUCTURE_LIMIT: cfg_limit  = value;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            answers_checked++;
            if (pending_answers.size() == 0) begin
                report_mismatch("result word with no answer owed", m_axis_tdata, 0);
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (m_axis_tdata[7:0] != oldest_answer.answer_byte)
                    report_mismatch("answer byte", m_axis_tdata[7:0], oldest_answer.answer_byte);
                if (m_axis_tuser != oldest_answer.answer_valid)
                    report_mismatch("answer valid", m_axis_tuser, oldest_answer.answer_valid);
                if (m_axis_tdata[9:8] != oldest_answer.status)
                    report_mismatch("status", m_axis_tdata[9:8], oldest_answer.status);
                if (m_axis_tdata[15:10] != '0)
                    report_mismatch("fill bits", m_axis_tdata[15:10], 0);
            end
        end
    end

    // The receiver stalls at random at the current rate.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("smbios_structure_string_finder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin : run
        t_result     typed;
        t_word       w;
        int          start_count;
        logic [7:0]  new_type;
        logic [7:0]  new_offset;
        logic [15:0] new_limit;

        cfg_type   = RST_WANTED_TYPE;
        cfg_offset = RST_WANTED_OFFSET;
        cfg_limit  = RST_STRUCTURE_LIMIT;
        restart_scan();

        // Scripted table. With the reset limit of zero a stray byte and a
        // restart both end the search at once.
        row_known(KIND_BYTE, 8'h00, ST_MISSING);
        row_known(KIND_RESTART, 8'hFF, ST_MISSING);
        row_write(CFG_STRUCTURE_LIMIT, 16'd4);
        row_write(CFG_WANTED_OFFSET, 16'd4);
        row_known(KIND_RESTART, 8'h00, ST_SEARCHING);
        // A type 2 structure with string number zero and no strings, then one
        // naming its second string "bc", then a byte after the search ended.
        foreach (sample_table[k]) row_word(KIND_BYTE, sample_table[k]);
        row_word(KIND_BYTE, 8'hFF);
        // End-of-table type, then a length too short for a header.
        row_known(KIND_RESTART, 8'h5A, ST_SEARCHING);
        row_known(KIND_BYTE, TYPE_END, ST_MISSING);
        row_known(KIND_RESTART, 8'h00, ST_SEARCHING);
        row_word(KIND_BYTE, 8'h02);
        row_known(KIND_BYTE, 8'h03, ST_MISSING);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                wait_until_idle();
                write_register(directed_rows[r].index, directed_rows[r].value);
            end else begin
                typed        = '0;
                typed.status = directed_rows[r].status;
                send_word(directed_rows[r].kind, directed_rows[r].data,
                          directed_rows[r].known, typed);
            end
        end

        // Random tables under a fresh register setting each time; the idling
        // pattern changes every third setting.
        for (int p = 0; p < SETTINGS_N; p++) begin
            wait_until_idle();
            if (p == 0) begin
                new_type   = 8'h00;
                new_offset = 8'h00;
                new_limit  = 16'd1;
            end else if (p == 1) begin
                new_type   = 8'hFF;
                new_offset = 8'hFF;
                new_limit  = 16'hFFFF;
            end else begin
                new_type   = 8'($urandom_range(255));
                new_offset = ($urandom_range(99) < 70) ? 8'($urandom_range(8))
                                                       : 8'($urandom_range(255));
                new_limit  = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 8)) : 16'hFFFF;
            end
            write_register(CFG_WANTED_TYPE, {8'h00, new_type});
            write_register(CFG_WANTED_OFFSET, {8'h00, new_offset});
            write_register(CFG_STRUCTURE_LIMIT, new_limit);
            case (p / 3)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            start_count = words_sent;
            while (words_sent - start_count < TABLE_WORDS / SETTINGS_N) begin
                table_words.delete();
                add_sequence();
                while (table_words.size() != 0) begin
                    w = table_words.pop_front();
                    send_word(w.kind, w.value, 1'b0, '0);
                end
            end
        end

        wait_until_idle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d table words (%0d while a search was live) under %0d settings;",
                 words_sent, live_words, SETTINGS_N);
        $display("checked %0d results: %0d searches found, %0d not found, %0d characters.",
                 answers_checked, found_searches, missing_searches, chars_streamed);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("smbios_structure_string_finder: match");
        end else begin
            $display("smbios_structure_string_finder: mismatch");
        end
        $finish;
    end

endmodule
